### hw/rtl/pbx_pkg.sv
// Shared widths, codes and types for the parabola breakpoint pipeline.
`default_nettype none
package pbx_pkg;

    // Field and datapath widths.
    localparam int CW     = 32;        // coordinate width
    localparam int ROOT_W = 65;        // square root width, one bit per root cell
    localparam int Q_W    = 2 * ROOT_W; // radicand width
    localparam int MAG_W  = 66;        // dividend magnitude width, one bit per divide cell
    localparam int DV_W   = 32;        // divisor magnitude width
    localparam int P_W    = 66;        // linear term a*d - c*b

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NEG_DISC = 2'd1;
    localparam logic [1:0] ST_SAT      = 2'd2;

    // How a beat's result is formed.
    typedef enum logic [1:0] {
        KIND_SOLVE,
        KIND_DIRECT,
        KIND_NEGDISC
    } t_kind;

    // Data riding along the square root chain.
    typedef struct packed {
        t_kind                  kind;
        logic [CW-1:0]          alt;
        logic signed [P_W-1:0]  p;
        logic                   den_neg;
        logic [DV_W-1:0]        dv;
    } t_sq_side;

    // Data riding along the divide chain.
    typedef struct packed {
        t_kind         kind;
        logic [CW-1:0] alt;
        logic          nneg;
        logic          den_neg;
    } t_dv_side;

endpackage
`default_nettype wire

### hw/rtl/parabola_breakpoint_x.sv
// Top level: beach-line breakpoint of two parabolic arcs, fully pipelined.
//
// Input stream (s side): one beat carries both foci and the sweep line y,
// all signed fixed point. Output stream (m side): one beat per input beat,
// in order, with the breakpoint x and a status code.
// Throughput: one beat per cycle while the receiver takes beats. The path from
// the accepting edge to o_m_tvalid runs through the 65-cell square root chain
// and the 66-cell divide chain, each cell settling one bit, plus six front
// stages for the products and four for sum, sign, rounding and the output register.
// Status 0 is a normal result, 1 a negative discriminant (x reads 0x7FFFFFFF),
// 2 a quotient out of range, saturated by its sign.
// Reset is synchronous and active low; it empties the pipeline and the output
// stage. There is no other state, so beats are independent.
// When the receiver stalls, the output register holds its beat and a skid
// register catches the one beat still in flight; the pipeline then stops and
// o_s_tready drops until the skid register drains.
`default_nettype none
module parabola_breakpoint_x
    import pbx_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    // left_focus_x, left_focus_y, right_focus_x, right_focus_y, sweep_y
    input  wire logic [159:0] i_s_tdata,
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // break_x, status, zero pad
    output logic [39:0]       o_m_tdata
);

    localparam int SQ_SIDE_W = $bits(t_sq_side);
    localparam int DV_SIDE_W = $bits(t_dv_side);

    logic w_en;

    // Stage 1: heights relative to the sweep line.
    logic                r1_valid;
    logic signed [31:0]  w_a, w_ly, w_c, w_ry, w_sw;
    logic signed [32:0]  n1_b, n1_d, n1_den, n1_ac;
    logic signed [31:0]  r1_a, r1_c;
    logic signed [32:0]  r1_b, r1_d, r1_den, r1_ac;

    assign w_a  = $signed(i_s_tdata[31:0]);
    assign w_ly = $signed(i_s_tdata[63:32]);
    assign w_c  = $signed(i_s_tdata[95:64]);
    assign w_ry = $signed(i_s_tdata[127:96]);
    assign w_sw = $signed(i_s_tdata[159:128]);

    always_comb begin
        n1_b   = w_sw - w_ly;
        n1_d   = w_sw - w_ry;
        n1_den = w_ly - w_ry;
        n1_ac  = w_a - w_c;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_a   <= w_a;
            r1_c   <= w_c;
            r1_b   <= n1_b;
            r1_d   <= n1_d;
            r1_den <= n1_den;
            r1_ac  <= n1_ac;
        end
    end

    // Stage 2: products, case selection and divisor magnitude.
    logic                r2_valid;
    logic signed [64:0]  n2_ad, n2_cb, r2_ad, r2_cb;
    logic signed [65:0]  n2_bd, n2_ac2, n2_den2, r2_bd;
    logic [64:0]         r2_ac2, r2_den2;
    logic signed [32:0]  w_sum;
    logic signed [32:0]  w_den_neg_v;
    t_kind               n2_kind, r2_kind;
    logic [CW-1:0]       n2_alt, r2_alt;
    logic [DV_W-1:0]     n2_dv, r2_dv;
    logic                r2_den_neg;

    always_comb begin
        n2_ad       = r1_a * r1_d;
        n2_cb       = r1_c * r1_b;
        n2_bd       = r1_b * r1_d;
        n2_ac2      = r1_ac * r1_ac;
        n2_den2     = r1_den * r1_den;
        w_sum       = r1_a + r1_c;
        w_den_neg_v = -r1_den;
        n2_dv       = r1_den[32] ? w_den_neg_v[31:0] : r1_den[31:0];
        // Degenerate cases come first, in priority order.
        if (r1_den == 33'sd0) begin
            n2_kind = KIND_DIRECT;
            n2_alt  = w_sum[32:1];
        end else if (r1_d == 33'sd0) begin
            n2_kind = KIND_DIRECT;
            n2_alt  = r1_c;
        end else if (r1_b == 33'sd0) begin
            n2_kind = KIND_DIRECT;
            n2_alt  = r1_a;
        end else if (r1_b[32] != r1_d[32]) begin
            n2_kind = KIND_NEGDISC;
            n2_alt  = 32'h7FFF_FFFF;
        end else begin
            n2_kind = KIND_SOLVE;
            n2_alt  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_ad      <= n2_ad;
            r2_cb      <= n2_cb;
            r2_bd      <= n2_bd;
            r2_ac2     <= n2_ac2[64:0];
            r2_den2    <= n2_den2[64:0];
            r2_kind    <= n2_kind;
            r2_alt     <= n2_alt;
            r2_dv      <= n2_dv;
            r2_den_neg <= r1_den[32];
        end
    end

    // Stage 3: linear term and sum of squares.
    logic                r3_valid;
    t_sq_side            n3_side, r3_side;
    logic [65:0]         n3_s, r3_s;
    logic [64:0]         r3_bdm;

    always_comb begin
        n3_side.kind    = r2_kind;
        n3_side.alt     = r2_alt;
        n3_side.p       = 66'(r2_ad) - 66'(r2_cb);
        n3_side.den_neg = r2_den_neg;
        n3_side.dv      = r2_dv;
        n3_s            = {1'b0, r2_ac2} + {1'b0, r2_den2};
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_side <= n3_side;
            r3_s    <= n3_s;
            r3_bdm  <= r2_bd[64:0];
        end
    end

    // Stage 4: radicand partial products, split near 33 bits.
    logic                r4_valid;
    t_sq_side            r4_side;
    logic [65:0]         n4_ll, n4_lh, r4_ll, r4_lh;
    logic [64:0]         n4_hl, n4_hh, r4_hl, r4_hh;

    always_comb begin
        n4_ll = r3_bdm[32:0] * r3_s[32:0];
        n4_lh = r3_bdm[32:0] * r3_s[65:33];
        n4_hl = 65'(r3_bdm[64:33] * r3_s[32:0]);
        n4_hh = 65'(r3_bdm[64:33] * r3_s[65:33]);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_side <= r3_side;
            r4_ll   <= n4_ll;
            r4_lh   <= n4_lh;
            r4_hl   <= n4_hl;
            r4_hh   <= n4_hh;
        end
    end

    // Stage 5: middle partial products.
    logic                r5_valid;
    t_sq_side            r5_side;
    logic [66:0]         n5_mid, r5_mid;
    logic [65:0]         r5_ll;
    logic [64:0]         r5_hh;

    assign n5_mid = {1'b0, r4_lh} + {2'b00, r4_hl};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_side <= r4_side;
            r5_mid  <= n5_mid;
            r5_ll   <= r4_ll;
            r5_hh   <= r4_hh;
        end
    end

    // Stage 6: full radicand, one quarter of the discriminant.
    logic                r6_valid;
    t_sq_side            r6_side;
    logic [Q_W-1:0]      n6_q, r6_q;

    assign n6_q = Q_W'({r5_hh, r5_ll}) + (Q_W'(r5_mid) << 33);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_side <= r5_side;
            r6_q    <= n6_q;
        end
    end

    // Square root chain.
    logic                  w_sq_v    [0:ROOT_W];
    logic [Q_W-1:0]        w_sq_q    [0:ROOT_W];
    logic [ROOT_W:0]       w_sq_rem  [0:ROOT_W];
    logic [ROOT_W-1:0]     w_sq_root [0:ROOT_W];
    logic [SQ_SIDE_W-1:0]  w_sq_side [0:ROOT_W];

    assign w_sq_v[0]    = r6_valid;
    assign w_sq_q[0]    = r6_q;
    assign w_sq_rem[0]  = '0;
    assign w_sq_root[0] = '0;
    assign w_sq_side[0] = r6_side;

    for (genvar gi = 0; gi < ROOT_W; gi++) begin : g_sq
        pbx_sqrt_cell #(
            .RTW (ROOT_W),
            .SW  (SQ_SIDE_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_sq_v[gi]),
            .i_q     (w_sq_q[gi]),
            .i_rem   (w_sq_rem[gi]),
            .i_root  (w_sq_root[gi]),
            .i_side  (w_sq_side[gi]),
            .o_valid (w_sq_v[gi+1]),
            .o_q     (w_sq_q[gi+1]),
            .o_rem   (w_sq_rem[gi+1]),
            .o_root  (w_sq_root[gi+1]),
            .o_side  (w_sq_side[gi+1])
        );
    end

    // Numerator: linear term plus root.
    t_sq_side            w_sq_out;
    logic                rn_valid;
    logic signed [66:0]  n_n, r_n;
    t_kind               rn_kind;
    logic [CW-1:0]       rn_alt;
    logic                rn_den_neg;
    logic [DV_W-1:0]     rn_dv;

    assign w_sq_out = t_sq_side'(w_sq_side[ROOT_W]);
    assign n_n      = 67'(w_sq_out.p) + $signed({2'b00, w_sq_root[ROOT_W]});

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_n        <= n_n;
            rn_kind    <= w_sq_out.kind;
            rn_alt     <= w_sq_out.alt;
            rn_den_neg <= w_sq_out.den_neg;
            rn_dv      <= w_sq_out.dv;
        end
    end

    // Numerator magnitude and sign.
    logic                rm_valid;
    logic signed [66:0]  w_n_neg_v;
    logic [MAG_W-1:0]    n_mag, r_mag;
    t_dv_side            n_m_side, r_m_side;
    logic [DV_W-1:0]     rm_dv;

    always_comb begin
        w_n_neg_v        = -r_n;
        n_mag            = r_n[66] ? w_n_neg_v[MAG_W-1:0] : r_n[MAG_W-1:0];
        n_m_side.kind    = rn_kind;
        n_m_side.alt     = rn_alt;
        n_m_side.nneg    = r_n[66];
        n_m_side.den_neg = rn_den_neg;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mag    <= n_mag;
            r_m_side <= n_m_side;
            rm_dv    <= rn_dv;
        end
    end

    // Divide chain.
    logic                  w_dv_v    [0:MAG_W];
    logic [MAG_W-1:0]      w_dv_num  [0:MAG_W];
    logic [DV_W-1:0]       w_dv_rem  [0:MAG_W];
    logic [MAG_W-1:0]      w_dv_quo  [0:MAG_W];
    logic [DV_W-1:0]       w_dv_dv   [0:MAG_W];
    logic [DV_SIDE_W-1:0]  w_dv_side [0:MAG_W];

    assign w_dv_v[0]    = rm_valid;
    assign w_dv_num[0]  = r_mag;
    assign w_dv_rem[0]  = '0;
    assign w_dv_quo[0]  = '0;
    assign w_dv_dv[0]   = rm_dv;
    assign w_dv_side[0] = r_m_side;

    for (genvar gj = 0; gj < MAG_W; gj++) begin : g_dv
        pbx_div_cell #(
            .NW (MAG_W),
            .DW (DV_W),
            .SW (DV_SIDE_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_dv_v[gj]),
            .i_num   (w_dv_num[gj]),
            .i_rem   (w_dv_rem[gj]),
            .i_quo   (w_dv_quo[gj]),
            .i_dv    (w_dv_dv[gj]),
            .i_side  (w_dv_side[gj]),
            .o_valid (w_dv_v[gj+1]),
            .o_num   (w_dv_num[gj+1]),
            .o_rem   (w_dv_rem[gj+1]),
            .o_quo   (w_dv_quo[gj+1]),
            .o_dv    (w_dv_dv[gj+1]),
            .o_side  (w_dv_side[gj+1])
        );
    end

    // Rounding toward minus infinity for a negative quotient.
    t_dv_side            w_dv_out;
    logic                w_qneg;
    logic                rf_valid;
    logic [MAG_W:0]      n_f_quo, r_f_quo;
    t_kind               rf_kind;
    logic [CW-1:0]       rf_alt;
    logic                rf_qneg;

    assign w_dv_out = t_dv_side'(w_dv_side[MAG_W]);
    assign w_qneg   = w_dv_out.nneg != w_dv_out.den_neg;
    assign n_f_quo  = {1'b0, w_dv_quo[MAG_W]}
                    + (MAG_W+1)'(w_qneg && (w_dv_rem[MAG_W] != '0));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f_quo <= n_f_quo;
            rf_kind <= w_dv_out.kind;
            rf_alt  <= w_dv_out.alt;
            rf_qneg <= w_qneg;
        end
    end

    // Range check, sign and final selection.
    logic          w_fits;
    logic [CW-1:0] w_res_x;
    logic [1:0]    w_res_st;
    logic [CW-1:0] w_signed_q;

    always_comb begin
        w_fits     = (r_f_quo[MAG_W:CW] == '0)
                   && (r_f_quo[CW-1:0] <= (rf_qneg ? 32'h8000_0000 : 32'h7FFF_FFFF));
        w_signed_q = rf_qneg ? (32'd0 - r_f_quo[CW-1:0]) : r_f_quo[CW-1:0];
        case (rf_kind)
            KIND_DIRECT: begin
                w_res_x  = rf_alt;
                w_res_st = ST_OK;
            end
            KIND_NEGDISC: begin
                w_res_x  = rf_alt;
                w_res_st = ST_NEG_DISC;
            end
            KIND_SOLVE: begin
                if (w_fits) begin
                    w_res_x  = w_signed_q;
                    w_res_st = ST_OK;
                end else begin
                    w_res_x  = rf_qneg ? 32'h8000_0000 : 32'h7FFF_FFFF;
                    w_res_st = ST_SAT;
                end
            end
            default: begin
                w_res_x  = rf_alt;
                w_res_st = ST_OK;
            end
        endcase
    end

    // Front-end and tail stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
            rn_valid <= 1'b0;
            rm_valid <= 1'b0;
            rf_valid <= 1'b0;
        end else if (w_en) begin
            r1_valid <= i_s_tvalid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
            r6_valid <= r5_valid;
            rn_valid <= w_sq_v[ROOT_W];
            rm_valid <= rn_valid;
            rf_valid <= w_dv_v[MAG_W];
        end
    end

    // Output register with a skid register behind it.
    logic          r_out_valid;
    logic [CW-1:0] r_out_x;
    logic [1:0]    r_out_st;
    logic          r_skid_valid;
    logic [CW-1:0] r_skid_x;
    logic [1:0]    r_skid_st;
    logic          w_deliver;
    logic          w_out_free;

    assign w_en       = !r_skid_valid;
    assign w_deliver  = w_en && rf_valid;
    assign w_out_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_deliver;
            end
        end else if (w_deliver) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            if (r_skid_valid) begin
                r_out_x  <= r_skid_x;
                r_out_st <= r_skid_st;
            end else begin
                r_out_x  <= w_res_x;
                r_out_st <= w_res_st;
            end
        end else if (w_deliver) begin
            r_skid_x  <= w_res_x;
            r_skid_st <= w_res_st;
        end
    end

    assign o_s_tready = w_en;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'b000000, r_out_st, r_out_x};

    // The skid register only fills behind a waiting output beat.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register full while output register empty");

    // The skid register fills only when the output beat was stalled.
    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && !i_m_tready))
        else $error("skid register loaded without a stall");

    // A negative discriminant always reads as the positive limit.
    a_negdisc_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_st == ST_NEG_DISC)) |-> (r_out_x == 32'h7FFF_FFFF))
        else $error("negative discriminant beat with wrong x");

endmodule
`default_nettype wire

### hw/rtl/pbx_sqrt_cell.sv
// One cell of the square root chain: settles one root bit per beat.
`default_nettype none
module pbx_sqrt_cell
    import pbx_pkg::*;
#(
    parameter int RTW = 65,
    parameter int SW  = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_valid,
    input  wire logic [2*RTW-1:0]     i_q,
    input  wire logic [RTW:0]         i_rem,
    input  wire logic [RTW-1:0]       i_root,
    input  wire logic [SW-1:0]        i_side,
    output logic                      o_valid,
    output logic [2*RTW-1:0]          o_q,
    output logic [RTW:0]              o_rem,
    output logic [RTW-1:0]            o_root,
    output logic [SW-1:0]             o_side
);

    localparam int QW = 2 * RTW;
    localparam int TW = RTW + 3;

    logic            r_valid;
    logic [QW-1:0]   r_q,    n_q;
    logic [RTW:0]    r_rem,  n_rem;
    logic [RTW-1:0]  r_root, n_root;
    logic [SW-1:0]   r_side;
    logic [TW-1:0]   w_part;
    logic [TW-1:0]   w_trial;

    // Bring down the next two radicand bits and try the next root bit.
    always_comb begin
        w_part  = {i_rem, i_q[QW-1 -: 2]};
        w_trial = {1'b0, i_root, 2'b01};
        n_q     = {i_q[QW-3:0], 2'b00};
        if (w_part >= w_trial) begin
            n_rem  = (RTW+1)'(w_part - w_trial);
            n_root = {i_root[RTW-2:0], 1'b1};
        end else begin
            n_rem  = w_part[RTW:0];
            n_root = {i_root[RTW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q    <= n_q;
            r_rem  <= n_rem;
            r_root <= n_root;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_q     = r_q;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_side  = r_side;

endmodule
`default_nettype wire

### hw/rtl/pbx_div_cell.sv
// One cell of the restoring divide chain: settles one quotient bit per beat.
`default_nettype none
module pbx_div_cell
    import pbx_pkg::*;
#(
    parameter int NW = 66,
    parameter int DW = 32,
    parameter int SW = 8
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_valid,
    input  wire logic [NW-1:0]  i_num,
    input  wire logic [DW-1:0]  i_rem,
    input  wire logic [NW-1:0]  i_quo,
    input  wire logic [DW-1:0]  i_dv,
    input  wire logic [SW-1:0]  i_side,
    output logic                o_valid,
    output logic [NW-1:0]       o_num,
    output logic [DW-1:0]       o_rem,
    output logic [NW-1:0]       o_quo,
    output logic [DW-1:0]       o_dv,
    output logic [SW-1:0]       o_side
);

    logic            r_valid;
    logic [NW-1:0]   r_num, n_num;
    logic [DW-1:0]   r_rem, n_rem;
    logic [NW-1:0]   r_quo, n_quo;
    logic [DW-1:0]   r_dv;
    logic [SW-1:0]   r_side;
    logic [DW:0]     w_part;

    // Shift in the next dividend bit and subtract the divisor if it fits.
    always_comb begin
        w_part = {i_rem, i_num[NW-1]};
        n_num  = {i_num[NW-2:0], 1'b0};
        if (w_part >= {1'b0, i_dv}) begin
            n_rem = DW'(w_part - {1'b0, i_dv});
            n_quo = {i_quo[NW-2:0], 1'b1};
        end else begin
            n_rem = w_part[DW-1:0];
            n_quo = {i_quo[NW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num  <= n_num;
            r_rem  <= n_rem;
            r_quo  <= n_quo;
            r_dv   <= i_dv;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_num   = r_num;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;
    assign o_dv    = r_dv;
    assign o_side  = r_side;

endmodule
`default_nettype wire
